// ===== rtl/core/fmdd_pkg.sv =====
// ----------------------------------------------------------------------------
// fmdd_pkg
// Shared types, constants and the CORDIC angle table of the FM discriminator.
// ----------------------------------------------------------------------------
package fmdd_pkg;

  localparam int ATAN_LEN   = 24;
  localparam int ATAN_IDX_W = 5;
  localparam int ANGLE_W    = 32;
  localparam int PHASE_W    = 16;
  localparam int GAIN_W     = 16;
  localparam int ACC_W      = 32;
  localparam int AUDIO_W    = 16;
  localparam int MUL_A_W    = 34;
  localparam int MUL_B_W    = 17;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_DEEMPH_RATE = 2'd0;
  localparam logic [1:0] REG_FM_GAIN     = 2'd1;
  localparam logic [1:0] REG_OUTPUT_GAIN = 2'd2;

  localparam logic [GAIN_W-1:0] DEEMPH_RATE_RST = 16'd0;
  localparam logic [GAIN_W-1:0] FM_GAIN_RST     = 16'd256;
  localparam logic [GAIN_W-1:0] OUTPUT_GAIN_RST = 16'd256;

  // datapath operations issued by the sequencer
  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_ITER,
    OP_CLEAR,
    OP_PHASE,
    OP_MUL_G,
    OP_SUB,
    OP_MUL_R,
    OP_ACC,
    OP_MUL_O,
    OP_RND_D,
    OP_MUL_B,
    OP_RND_B,
    OP_FIN
  } dp_op_t;

  typedef struct packed {
    logic mute;       // captured sample is muted
    logic last_step;  // final CORDIC iteration this cycle
    logic bypass;     // de-emphasis off
    logic out_free;   // output register can take a beat
  } dp_status_t;

  // atan(2^-k) in units of 2^-31 half rotations
  function automatic logic [ANGLE_W-1:0] atan_angle(input logic [ATAN_IDX_W-1:0] idx);
    logic [ANGLE_W-1:0] a;
    case (idx)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/core/fmdd_regs.sv =====
// ----------------------------------------------------------------------------
// fmdd_regs
// APB register file: de-emphasis rate, FM gain and output gain.
// ----------------------------------------------------------------------------
module fmdd_regs
  import fmdd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [GAIN_W-1:0]     deemph_rate,
  output logic [GAIN_W-1:0]     fm_gain,
  output logic [GAIN_W-1:0]     output_gain
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      deemph_rate <= DEEMPH_RATE_RST;
      fm_gain     <= FM_GAIN_RST;
      output_gain <= OUTPUT_GAIN_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_DEEMPH_RATE: deemph_rate <= pwdata[GAIN_W-1:0];
        REG_FM_GAIN:     fm_gain     <= pwdata[GAIN_W-1:0];
        REG_OUTPUT_GAIN: output_gain <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DEEMPH_RATE: prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, deemph_rate};
      REG_FM_GAIN:     prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, fm_gain};
      REG_OUTPUT_GAIN: prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, output_gain};
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/fmdd_ctrl.sv =====
// ----------------------------------------------------------------------------
// fmdd_ctrl
// Sequencer: steps the datapath through CORDIC, differencing and scaling.
// ----------------------------------------------------------------------------
module fmdd_ctrl
  import fmdd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_op_t     op
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_ITER  = 12'b0000_0000_0010,
    S_PHASE = 12'b0000_0000_0100,
    S_MUL_G = 12'b0000_0000_1000,
    S_SUB   = 12'b0000_0001_0000,
    S_MUL_R = 12'b0000_0010_0000,
    S_ACC   = 12'b0000_0100_0000,
    S_MUL_O = 12'b0000_1000_0000,
    S_RND_D = 12'b0001_0000_0000,
    S_MUL_B = 12'b0010_0000_0000,
    S_RND_B = 12'b0100_0000_0000,
    S_FIN   = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op         = OP_INIT;
          state_next = S_ITER;
        end
      end
      S_ITER: begin
        if (status.mute) begin
          op         = OP_CLEAR;
          state_next = S_FIN;
        end else begin
          op = OP_ITER;
          if (status.last_step) state_next = S_PHASE;
        end
      end
      S_PHASE: begin
        op         = OP_PHASE;
        state_next = status.bypass ? S_MUL_B : S_MUL_G;
      end
      S_MUL_G: begin
        op         = OP_MUL_G;
        state_next = S_SUB;
      end
      S_SUB: begin
        op         = OP_SUB;
        state_next = S_MUL_R;
      end
      S_MUL_R: begin
        op         = OP_MUL_R;
        state_next = S_ACC;
      end
      S_ACC: begin
        op         = OP_ACC;
        state_next = S_MUL_O;
      end
      S_MUL_O: begin
        op         = OP_MUL_O;
        state_next = S_RND_D;
      end
      S_RND_D: begin
        op         = OP_RND_D;
        state_next = S_FIN;
      end
      S_MUL_B: begin
        op         = OP_MUL_B;
        state_next = S_RND_B;
      end
      S_RND_B: begin
        op         = OP_RND_B;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (status.out_free) begin
          op         = OP_FIN;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/fmdd_dp.sv =====
// ----------------------------------------------------------------------------
// fmdd_dp
// Datapath: iterative CORDIC, phase difference, shared multiplier,
// de-emphasis state and the output register.
// ----------------------------------------------------------------------------
module fmdd_dp
  import fmdd_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  dp_op_t                         op,
  output dp_status_t                     status,
  input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] q_sample,
  input  logic                           mute,
  input  logic [GAIN_W-1:0]              deemph_rate,
  input  logic [GAIN_W-1:0]              fm_gain,
  input  logic [GAIN_W-1:0]              output_gain,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic signed [AUDIO_W-1:0]      audio_sample,
  output logic                           muted,
  output logic                           saturated
);

  localparam int NSTEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int KW     = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;
  localparam int XW     = SAMPLE_WIDTH + 3;   // CORDIC gain and sign flip headroom

  localparam logic signed [ACC_W+3:0]  ACC_MAX = 36'sh07FFFFFFF;
  localparam logic signed [ACC_W+3:0]  ACC_MIN = 36'shF80000000;
  localparam logic signed [PROD_W-1:0] AUD_MAX = 51'sd32767;
  localparam logic signed [PROD_W-1:0] AUD_MIN = -51'sd32768;
  localparam logic signed [PROD_W-1:0] HALF_D  = 51'sd32768;
  localparam logic signed [PROD_W-1:0] HALF_B  = 51'sd128;

  // CORDIC
  logic signed [XW-1:0]      x, y;
  logic signed [XW-1:0]      xi, yi;
  logic [ANGLE_W-1:0]        angle;
  logic [KW-1:0]             k;
  logic                      zero_in;
  logic                      mute_q;
  logic [ANGLE_W-1:0]        angle_rnd;
  logic [PHASE_W-1:0]        phase_v;

  // difference and scaling
  logic [PHASE_W-1:0]        prev_phase;
  logic signed [PHASE_W-1:0] diff;
  logic signed [ACC_W-1:0]   acc;
  logic signed [MUL_A_W-1:0] dreg;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W+3:0]   acc_sum;
  logic signed [PROD_W-1:0]  rnd_sum;
  logic signed [PROD_W-1:0]  rnd_val;
  logic signed [AUDIO_W-1:0] res_audio;
  logic                      res_sat;

  assign xi = {{3{i_sample[SAMPLE_WIDTH-1]}}, i_sample};
  assign yi = {{3{q_sample[SAMPLE_WIDTH-1]}}, q_sample};

  assign angle_rnd = angle + 32'h0000_8000;
  assign phase_v   = zero_in ? '0 : angle_rnd[ANGLE_W-1:ANGLE_W-PHASE_W];

  assign status.mute      = mute_q;
  assign status.last_step = (k == KW'(NSTEPS - 1));
  assign status.bypass    = (deemph_rate == '0);
  assign status.out_free  = !out_valid || out_ready;

  always_comb begin
    case (op)
      OP_MUL_G: begin
        mul_a = {{(MUL_A_W-PHASE_W){diff[PHASE_W-1]}}, diff};
        mul_b = {1'b0, fm_gain};
      end
      OP_MUL_R: begin
        mul_a = dreg;
        mul_b = {1'b0, deemph_rate};
      end
      OP_MUL_O: begin
        mul_a = {{(MUL_A_W-ACC_W){acc[ACC_W-1]}}, acc};
        mul_b = {1'b0, output_gain};
      end
      default: begin
        mul_a = {{(MUL_A_W-PHASE_W){diff[PHASE_W-1]}}, diff};
        mul_b = {1'b0, output_gain};
      end
    endcase
  end

  assign acc_sum = {{4{acc[ACC_W-1]}}, acc} + {prod[PROD_W-1], prod[PROD_W-1:16]};
  assign rnd_sum = prod + ((op == OP_RND_D) ? HALF_D : HALF_B);
  assign rnd_val = (op == OP_RND_D) ? (rnd_sum >>> 16) : (rnd_sum >>> 8);

  // working registers
  always_ff @(posedge clk) begin
    case (op) inside
      OP_INIT: begin
        x       <= i_sample[SAMPLE_WIDTH-1] ? -xi : xi;
        y       <= i_sample[SAMPLE_WIDTH-1] ? -yi : yi;
        angle   <= i_sample[SAMPLE_WIDTH-1] ? 32'h8000_0000 : 32'h0000_0000;
        zero_in <= (i_sample == '0) && (q_sample == '0);
        mute_q  <= mute;
        k       <= '0;
      end
      OP_ITER: begin
        if (!y[XW-1]) begin
          x     <= x + (y >>> k);
          y     <= y - (x >>> k);
          angle <= angle + atan_angle(ATAN_IDX_W'(k));
        end else begin
          x     <= x - (y >>> k);
          y     <= y + (x >>> k);
          angle <= angle - atan_angle(ATAN_IDX_W'(k));
        end
        k <= k + 1'b1;
      end
      OP_CLEAR: begin
        res_audio <= '0;
        res_sat   <= 1'b0;
      end
      OP_PHASE: diff <= phase_v - prev_phase;
      OP_MUL_G, OP_MUL_R, OP_MUL_O, OP_MUL_B: prod <= mul_a * mul_b;
      OP_SUB: dreg <= {{2{prod[31]}}, prod[31:0]} - {{2{acc[ACC_W-1]}}, acc};
      OP_RND_D, OP_RND_B: begin
        if (rnd_val > AUD_MAX) begin
          res_audio <= 16'sh7FFF;
          res_sat   <= 1'b1;
        end else if (rnd_val < AUD_MIN) begin
          res_audio <= 16'sh8000;
          res_sat   <= 1'b1;
        end else begin
          res_audio <= rnd_val[AUDIO_W-1:0];
          res_sat   <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_phase <= '0;
      acc        <= '0;
    end else begin
      if (op == OP_CLEAR) prev_phase <= '0;
      if (op == OP_PHASE) prev_phase <= phase_v;
      if (op == OP_ACC) begin
        if (acc_sum > ACC_MAX)      acc <= 32'sh7FFF_FFFF;
        else if (acc_sum < ACC_MIN) acc <= 32'sh8000_0000;
        else                        acc <= acc_sum[ACC_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_FIN) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_FIN) begin
      audio_sample <= res_audio;
      muted        <= mute_q;
      saturated    <= res_sat;
    end
  end

endmodule

// ===== rtl/core/fm_discriminator_deemphasis_top.sv =====
// ----------------------------------------------------------------------------
// fm_discriminator_deemphasis_top
// FM quadrature discriminator: CORDIC phase, wrapped phase difference,
// optional one-pole de-emphasis, output gain and 16-bit saturation.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_ready  i_sample, q_sample, mute
//   output   out        out_valid/out_ready  audio_sample, muted, saturated
//   config   in         APB (psel/penable)   paddr, pwdata -> prdata
//
// Sequence: the iterative CORDIC, one rotation a cycle, runs first and the
//   shared multiplier steps follow it, fewer of them in bypass; a muted
//   sample skips both.
// Reset: synchronous, active high; clears phase memory and de-emphasis
//   state, loads register defaults (rate 0, both gains 1.0).
// Stalls: a finished beat sits in the output register; the next sample is
//   taken meanwhile and waits in its last step only if that beat is unsent.
// ----------------------------------------------------------------------------
module fm_discriminator_deemphasis_top
  import fmdd_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // sample input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] q_sample,
  input  logic                           mute,
  // audio output
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [AUDIO_W-1:0]      audio_sample,
  output logic                           muted,
  output logic                           saturated,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [APB_ADDR_W-1:0]          paddr,
  input  logic [APB_DATA_W-1:0]          pwdata,
  output logic [APB_DATA_W-1:0]          prdata,
  output logic                           pready
);

  logic [GAIN_W-1:0] deemph_rate;
  logic [GAIN_W-1:0] fm_gain;
  logic [GAIN_W-1:0] output_gain;
  dp_op_t            op;
  dp_status_t        status;

  fmdd_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .deemph_rate (deemph_rate),
    .fm_gain     (fm_gain),
    .output_gain (output_gain)
  );

  // sequencer: takes a sample only when idle
  fmdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .op       (op)
  );

  // datapath: CORDIC, difference, de-emphasis, output register
  fmdd_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .status       (status),
    .i_sample     (i_sample),
    .q_sample     (q_sample),
    .mute         (mute),
    .deemph_rate  (deemph_rate),
    .fm_gain      (fm_gain),
    .output_gain  (output_gain),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .audio_sample (audio_sample),
    .muted        (muted),
    .saturated    (saturated)
  );

endmodule

// ===== rtl/core/fmdd_checker.sv =====
// ----------------------------------------------------------------------------
// fmdd_checker
// Port-level checks on the discriminator, bound to the top level.
// ----------------------------------------------------------------------------
module fmdd_checker
  import fmdd_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [AUDIO_W-1:0] audio_sample,
  input logic                      muted,
  input logic                      saturated,
  input logic                      pready
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(audio_sample)
      && $stable(muted) && $stable(saturated))
    else $error("output beat changed while stalled");

  // one sample at a time: no accept in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a sample is in flight");

  // muted beat carries zero and no clip flag
  a_muted_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && muted |-> audio_sample == '0 && !saturated)
    else $error("muted beat not zero");

  // clip flag only at the rails
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> audio_sample == 16'sh7FFF || audio_sample == 16'sh8000)
    else $error("saturated beat not at a rail");

  // register port never waits
  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready low");

endmodule

bind fm_discriminator_deemphasis_top fmdd_checker u_fmdd_checker (.*);

// ===== verif/fm_discriminator_deemphasis_top_tb.sv =====
// ----------------------------------------------------------------------------
// fm_discriminator_deemphasis_top_tb
// Self-checking bench for the FM discriminator. A short table of corner
// samples runs first at reset settings. Randomised runs follow under a range
// of register settings, with gaps and stalls on both channels. Every audio
// beat is checked against a bit-exact model of the CORDIC phase, the wrapped
// phase difference, de-emphasis lowpass and output gain, or a fixed row's typed result.
// ----------------------------------------------------------------------------
module fm_discriminator_deemphasis_top_tb;
  import fmdd_pkg::*;

  localparam int SAMPLE_WIDTH = 16;
  localparam int CORDIC_STEPS = 16;
  // the angle table only has 24 entries; more steps behave as 24
  localparam int ROT_STEPS    = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;   // comfortably past the time one sample takes
  localparam int HOLD_CYCLES  = 400;  // long receiver hold-off

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  // one IQ beat; the fixed flag marks rows whose result is typed in by hand
  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] i;
    logic signed [SAMPLE_WIDTH-1:0] q;
    logic                           mute;
    logic                           fixed;
    logic signed [AUDIO_W-1:0]      w_audio;
    logic                           w_muted;
    logic                           w_sat;
  } iq_beat_t;

  typedef struct packed {
    logic signed [AUDIO_W-1:0] audio;
    logic                      muted;
    logic                      sat;
  } audio_beat_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  iq_beat_t                       cur_iq = '0;
  logic signed [SAMPLE_WIDTH-1:0] i_sample;
  logic signed [SAMPLE_WIDTH-1:0] q_sample;
  logic                           mute;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic signed [AUDIO_W-1:0]      audio_sample;
  logic                           muted;
  logic                           saturated;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]          paddr = '0;
  logic [APB_DATA_W-1:0]          pwdata = '0;
  logic [APB_DATA_W-1:0]          prdata;
  logic                           pready;

  // payload ports follow the beat on offer
  assign i_sample = cur_iq.i;
  assign q_sample = cur_iq.q;
  assign mute     = cur_iq.mute;

  fm_discriminator_deemphasis_top #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .i_sample    (i_sample),
    .q_sample    (q_sample),
    .mute        (mute),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .audio_sample(audio_sample),
    .muted       (muted),
    .saturated   (saturated),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Model state: register copies, phase memory and lowpass accumulator
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0] cfg_reg [3];
  logic [PHASE_W-1:0] phase_mem = '0;
  longint             lp_acc = 0;   // units of 2^-23, kept within 32 bits
  logic [ANGLE_W-1:0] atan_lut [ATAN_LEN];

  iq_beat_t    send_q [$];       // beats waiting for the driver
  audio_beat_t audio_due_q [$];  // audio beats owed by the block
  int          err_cnt = 0;
  int          beat_cnt = 0;
  int          cycle_cnt = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_len = 0;
  int          hold_tag = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  initial begin
    cfg_reg[REG_DEEMPH_RATE] = DEEMPH_RATE_RST;
    cfg_reg[REG_FM_GAIN]     = FM_GAIN_RST;
    cfg_reg[REG_OUTPUT_GAIN] = OUTPUT_GAIN_RST;
    atan_lut = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
                 32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
                 32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
                 32'd166886,    32'd83443,     32'd41722,     32'd20861,
                 32'd10430,     32'd5215,      32'd2608,      32'd1304,
                 32'd652,       32'd326,       32'd163,       32'd81};
  end

  // vectoring CORDIC: angle of (x, y) in half rotations, rounded to Q1.15
  function automatic logic [PHASE_W-1:0] phase_of(longint xs, longint ys);
    longint             x, y, dx, dy;
    logic [ANGLE_W-1:0] ang;
    logic [ANGLE_W-1:0] rnd;
    int                 k;
    x   = xs;
    y   = ys;
    ang = '0;
    if (x == 0 && y == 0) return '0;
    // left half plane: turn by half a rotation first
    if (x < 0) begin
      x   = -x;
      y   = -y;
      ang = 32'h8000_0000;
    end
    for (k = 0; k < ROT_STEPS; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (y >= 0) begin
        x   = x + dx;
        y   = y - dy;
        ang = ang + atan_lut[k];
      end else begin
        x   = x - dx;
        y   = y + dy;
        ang = ang - atan_lut[k];
      end
    end
    rnd = ang + 32'h0000_8000;
    return rnd[ANGLE_W-1:16];
  endfunction

  // one sample through the discriminator; updates phase memory and lowpass
  function automatic audio_beat_t demodulate(iq_beat_t s);
    audio_beat_t        r;
    logic [PHASE_W-1:0] ph;
    logic [PHASE_W-1:0] d16;
    longint             diff, gx, acc, scaled;
    r = '0;
    if (s.mute) begin
      // closed squelch: forget the phase, keep the lowpass
      phase_mem = '0;
      r.muted   = 1'b1;
      return r;
    end
    ph        = phase_of(longint'($signed(s.i)), longint'($signed(s.q)));
    d16       = ph - phase_mem;   // modulo one rotation, so +1 lands on -1
    diff      = longint'($signed(d16));
    phase_mem = ph;
    if (cfg_reg[REG_DEEMPH_RATE] != '0) begin
      gx  = longint'(cfg_reg[REG_FM_GAIN]) * diff;
      acc = lp_acc;
      acc = acc + ((longint'(cfg_reg[REG_DEEMPH_RATE]) * (gx - acc)) >>> 16);
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      lp_acc = acc;
      scaled = (acc * longint'(cfg_reg[REG_OUTPUT_GAIN]) + 32768) >>> 16;
    end else begin
      scaled = (diff * longint'(cfg_reg[REG_OUTPUT_GAIN]) + 128) >>> 8;
    end
    if (scaled > 32767) begin
      scaled = 32767;
      r.sat  = 1'b1;
    end else if (scaled < -32768) begin
      scaled = -32768;
      r.sat  = 1'b1;
    end
    r.audio = 16'(scaled);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("beat %0d: %s mismatch, got %0d want %0d", beat_cnt, what, got, want);
    err_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // Sample driver: a new beat may go up once the last one is taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (send_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        cur_iq   <= send_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Audio receiver: random stalls, plus a long hold-off when asked for
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_tag != hold_seen) begin
      hold_seen = hold_tag;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Checker. Outputs are matched before new inputs are predicted, so an
  // audio beat can never be paired with a sample taken at the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    audio_beat_t due;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (audio_due_q.size() == 0) begin
          report_mismatch("unrequested audio beat", $signed(audio_sample), 0);
        end else begin
          due = audio_due_q.pop_front();
          if (audio_sample !== due.audio)
            report_mismatch("audio_sample", $signed(audio_sample), $signed(due.audio));
          if (muted !== due.muted)
            report_mismatch("muted", muted, due.muted);
          if (saturated !== due.sat)
            report_mismatch("saturated", saturated, due.sat);
        end
        beat_cnt++;
      end
      if (in_valid && in_ready) begin
        due = demodulate(cur_iq);   // model state moves on either way
        if (cur_iq.fixed) begin
          due.audio = cur_iq.w_audio;
          due.muted = cur_iq.w_muted;
          due.sat   = cur_iq.w_sat;
        end
        audio_due_q.push_back(due);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("fm_discriminator_deemphasis_top_tb: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Register port
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [1:0] idx, logic [GAIN_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= APB_DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // written at this edge
    cfg_reg[idx] = val;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic read_reg_check(logic [1:0] idx);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[GAIN_W-1:0] !== cfg_reg[idx])
      report_mismatch("register readback", prdata[GAIN_W-1:0], cfg_reg[idx]);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_idle(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SEND: begin
        send_idle_pct  = 88;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_idle_pct  = 0;
        recv_stall_pct = 88;
      end
      default: begin
        send_idle_pct  = 13;
        recv_stall_pct = 13;
      end
    endcase
  endtask

  // block idle: nothing queued, nothing on offer, nothing owed
  task automatic wait_drained();
    do @(negedge clk);
    while (send_q.size() != 0 || in_valid || audio_due_q.size() != 0);
  endtask

  // One setting of the registers, then random samples in two halves with a
  // full drain between them.
  task automatic run_phase(logic [GAIN_W-1:0] rate, logic [GAIN_W-1:0] fmg,
                           logic [GAIN_W-1:0] outg, int n_items,
                           idle_mode_t mode, bit hold);
    iq_beat_t s;
    int       k, sel;
    write_reg(REG_DEEMPH_RATE, rate);
    write_reg(REG_FM_GAIN, fmg);
    write_reg(REG_OUTPUT_GAIN, outg);
    read_reg_check(REG_DEEMPH_RATE);
    read_reg_check(REG_FM_GAIN);
    read_reg_check(REG_OUTPUT_GAIN);
    @(negedge clk);
    set_idle(mode);
    if (hold) begin
      // receiver shut for a long stretch while samples keep coming
      hold_len = HOLD_CYCLES;
      hold_tag = hold_tag + 1;
    end
    for (k = 0; k < n_items; k++) begin
      if (k == n_items / 2) wait_drained();
      s   = '0;
      sel = $urandom_range(99);
      if (sel < 10) begin
        s.mute = 1'b1;
        s.i    = 16'($urandom_range(65535));
        s.q    = 16'($urandom_range(65535));
      end else if (sel < 15) begin
        s.i = '0;
        s.q = '0;
      end else if (sel < 30) begin
        // axes and corners
        case ($urandom_range(4))
          0: s.i = 16'h8000;
          1: s.i = 16'hFFFF;
          2: s.i = 16'h0000;
          3: s.i = 16'h0001;
          default: s.i = 16'h7FFF;
        endcase
        case ($urandom_range(4))
          0: s.q = 16'h8000;
          1: s.q = 16'hFFFF;
          2: s.q = 16'h0000;
          3: s.q = 16'h0001;
          default: s.q = 16'h7FFF;
        endcase
      end else if (sel < 45) begin
        // weak signal near the origin
        s.i = 16'($signed($urandom_range(64)) - 32);
        s.q = 16'($signed($urandom_range(64)) - 32);
      end else begin
        s.i = 16'($urandom_range(65535));
        s.q = 16'($urandom_range(65535));
      end
      send_q.push_back(s);
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Directed rows: i, q, mute, fixed, then the typed result where fixed
  // --------------------------------------------------------------------------
  iq_beat_t dir_rows [22];

  initial begin
    int r;
    dir_rows = '{
      '{16'h0000, 16'h0000, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b0},  // mute after reset
      '{16'h0000, 16'h0000, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b0},  // zero input
      '{16'h7FFF, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h8000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},  // negative real axis
      '{16'h7FFF, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},  // half-rotation step
      '{16'h0000, 16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h0000, 16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h8000, 16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h8000, 16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h7FFF, 16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h0001, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'hFFFF, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h0000, 16'h0001, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h8000, 16'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},  // just above -pi
      '{16'h8000, 16'h0001, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},  // just below +pi
      '{16'h7FFF, 16'h8000, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b0},  // mute ignores payload
      '{16'h0000, 16'h0000, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b0},  // zero after mute
      '{16'h5A5A, 16'hA5A5, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'hA5A5, 16'h5A5A, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0}   // zero after a phase
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset values first, then the directed rows at reset settings
    read_reg_check(REG_DEEMPH_RATE);
    read_reg_check(REG_FM_GAIN);
    read_reg_check(REG_OUTPUT_GAIN);
    @(negedge clk);
    set_idle(IDLE_NONE);
    for (r = 0; r < 22; r++) send_q.push_back(dir_rows[r]);
    wait_drained();

    // rate, fm_gain, output_gain, samples, idling, hold-off
    run_phase(16'd0,     16'd256,   16'd256,   90,  IDLE_NONE, 1'b0);
    run_phase(16'd0,     16'd256,   16'hFFFF,  90,  IDLE_SEND, 1'b0);  // clips hard
    run_phase(16'hFFFF,  16'hFFFF,  16'hFFFF,  90,  IDLE_RECV, 1'b0);  // output clips
    run_phase(16'd1,     16'd256,   16'd256,   90,  IDLE_BOTH, 1'b0);
    run_phase(16'h2000,  16'h0100,  16'h0800,  100, IDLE_NONE, 1'b1);
    run_phase(16'd0,     16'd0,     16'd0,     60,  IDLE_SEND, 1'b0);
    run_phase(16'h8000,  16'h4000,  16'h0040,  80,  IDLE_RECV, 1'b0);
    run_phase(16'($urandom_range(65535)), 16'($urandom_range(65535)),
              16'($urandom_range(65535)), 80, IDLE_BOTH, 1'b0);
    run_phase(16'hFFFF,  16'd0,     16'd256,   70,  IDLE_NONE, 1'b0);

    wait_drained();
    // let any stray beat show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && audio_due_q.size() == 0) begin
      $display("fm_discriminator_deemphasis_top_tb: clean");
    end else begin
      $display("fm_discriminator_deemphasis_top_tb: errors");
    end
    $finish;
  end

endmodule
